// ===== sv/psms_pkg.sv =====
`default_nettype none

package psms_pkg;

	localparam int PIX_W    = 16;
	localparam int SUM_W    = 36;
	localparam int SQ_W     = 51;
	localparam int CNT_W    = 21;
	localparam int MEAN_W   = 24;
	localparam int SD_W     = 24;
	localparam int DVD_W    = 44;  // 256*|sum| and the square root both fit here
	localparam int PROD_W   = 72;  // N*Q and S*S
	localparam int DIFF_W   = PROD_W + 1;
	localparam int RAD_W    = PROD_W + 16;
	localparam int REM_W    = 46;
	localparam int STEP_W   = 6;
	localparam int FIFO_DEPTH = 2;

	localparam logic [CNT_W-1:0] MAX_PIXELS = CNT_W'(1048576);

	typedef struct packed {
		logic signed [PIX_W-1:0] pixel;
		logic                    pixel_valid;
		logic                    frame_last;
	} pix_in_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] total;
		logic signed [MEAN_W-1:0] mean_q8;
		logic [SD_W-1:0]         std_dev_q8;
		logic [CNT_W-1:0]        valid_count;
	} stat_out_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic [SQ_W-1:0]         sumsq;
		logic [CNT_W-1:0]        count;
	} frame_rec_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
		logic [CNT_W-1:0] remainder;
	} div_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MEAN,
		ST_MUL_NQ,
		ST_MUL_SS,
		ST_SQRT,
		ST_SD,
		ST_OUT
	} back_state_t;

endpackage

`default_nettype wire

// ===== sv/pixel_sum_mean_stddev.sv =====
// Per-frame pixel statistics: sum, Q8 mean and Q8 population standard deviation.
// Input channel: push/full with item (pixel, pixel_valid, frame_last). A pixel is
// taken on each edge where push is high and full is low, so a frame streams at
// one pixel per cycle. Valid pixels are accumulated; past 1048576 they are dropped.
// Output channel: empty/pop with result (total, mean_q8, std_dev_q8, valid_count).
// The head result stays on result while empty is low and leaves on pop.
// One result per frame with at least one valid pixel; empty frames give none.
// The accumulators clear on every frame_last pixel, so the next frame can
// follow in the next cycle. Finished frames wait in a two-entry queue while the
// back end works through them one at a time: a divide for the mean, 21 + 36
// shift-add steps for N*Q - S*S, 44 square-root steps and a second divide.
// Short frames that arrive faster than the back end finishes them can stall the
// input once the queue holds two frames.
// When pop is held low the finished result waits in the output register and the
// back end stops after its next frame; full then rises once the queue fills.
// Reset (arst_n low) clears accumulators, queue and output; no result is pending.

`default_nettype none

module pixel_sum_mean_stddev (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	output logic                full,
	input  psms_pkg::pix_in_t   item,
	output logic                empty,
	input  wire                 pop,
	output psms_pkg::stat_out_t result
);
	import psms_pkg::*;

	logic       q_full;
	logic       rec_push;
	frame_rec_t rec_w;
	logic       rec_valid;
	frame_rec_t rec_head;
	logic       rec_pop;
	div_req_t   div_req;
	div_rsp_t   div_rsp;

	psms_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.q_full   (q_full),
		.rec_push (rec_push),
		.rec      (rec_w)
	);

	psms_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (rec_push),
		.wr_data  (rec_w),
		.q_full   (q_full),
		.rd_en    (rec_pop),
		.rd_valid (rec_valid),
		.rd_data  (rec_head)
	);

	psms_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	psms_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (rec_valid),
		.rec       (rec_head),
		.rec_pop   (rec_pop),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

`default_nettype wire

// ===== sv/psms_front.sv =====
`default_nettype none

module psms_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  psms_pkg::pix_in_t    item,
	output logic                 full,
	input  wire                  q_full,
	output logic                 rec_push,
	output psms_pkg::frame_rec_t rec
);
	import psms_pkg::*;

	logic signed [SUM_W-1:0] sum_q;
	logic [SQ_W-1:0]         sumsq_q;
	logic [CNT_W-1:0]        cnt_q;

	logic                    accept;
	logic                    take;
	logic signed [PIX_W-1:0] pix_s;
	logic signed [2*PIX_W-1:0] sq_s;
	logic signed [SUM_W-1:0] sum_n;
	logic [SQ_W-1:0]         sumsq_n;
	logic [CNT_W-1:0]        cnt_n;

	assign full   = q_full;
	assign accept = push && !q_full;

	always_comb begin
		pix_s = item.pixel;
		sq_s  = pix_s * pix_s;
		take  = item.pixel_valid && (cnt_q < MAX_PIXELS);
		cnt_n = cnt_q;
		sum_n = sum_q;
		sumsq_n = sumsq_q;
		if (take) begin
			cnt_n   = cnt_q + CNT_W'(1);
			sum_n   = sum_q + {{(SUM_W-PIX_W){pix_s[PIX_W-1]}}, pix_s};
			sumsq_n = sumsq_q + SQ_W'(unsigned'(sq_s));
		end
		rec.sum   = sum_n;
		rec.sumsq = sumsq_n;
		rec.count = cnt_n;
		// empty frames produce no request downstream
		rec_push  = accept && item.frame_last && (cnt_n != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			sumsq_q <= '0;
			cnt_q   <= '0;
		end else if (accept) begin
			if (item.frame_last) begin
				sum_q   <= '0;
				sumsq_q <= '0;
				cnt_q   <= '0;
			end else begin
				sum_q   <= sum_n;
				sumsq_q <= sumsq_n;
				cnt_q   <= cnt_n;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/psms_fifo.sv =====
`default_nettype none

module psms_fifo (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  wr_en,
	input  psms_pkg::frame_rec_t wr_data,
	output logic                 q_full,
	input  wire                  rd_en,
	output logic                 rd_valid,
	output psms_pkg::frame_rec_t rd_data
);
	import psms_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);

	frame_rec_t           mem [FIFO_DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [PTR_W:0]       cnt_q;
	logic                 do_wr;
	logic                 do_rd;

	assign q_full   = (cnt_q == (PTR_W+1)'(FIFO_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem[rd_ptr_q];
	assign do_wr    = wr_en && !q_full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr)
			mem[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH-1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH-1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + (PTR_W+1)'(1);
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - (PTR_W+1)'(1);
		end
	end

endmodule

`default_nettype wire

// ===== sv/psms_div.sv =====
`default_nettype none

// restoring divider, one quotient bit per cycle
module psms_div (
	input  wire                clk,
	input  wire                arst_n,
	input  psms_pkg::div_req_t req,
	output psms_pkg::div_rsp_t rsp
);
	import psms_pkg::*;

	logic [DVD_W-1:0]  dvd_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dsr_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;

	logic [CNT_W:0]    rem2;
	logic              ge;
	logic [CNT_W:0]    diff;

	always_comb begin
		rem2 = {rem_q, dvd_q[DVD_W-1]};
		ge   = (rem2 >= {1'b0, dsr_q});
		diff = rem2 - {1'b0, dsr_q};
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = dvd_q;
	assign rsp.remainder = rem_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
			// remainder stays below the divisor
			rem_q <= ge ? diff[CNT_W-1:0] : rem2[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(DVD_W-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/psms_back.sv =====
`default_nettype none

module psms_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   rec_valid,
	input  psms_pkg::frame_rec_t  rec,
	output logic                  rec_pop,
	output psms_pkg::div_req_t    div_req,
	input  psms_pkg::div_rsp_t    div_rsp,
	input  wire                   pop,
	output logic                  empty,
	output psms_pkg::stat_out_t   result
);
	import psms_pkg::*;

	back_state_t state_q, state_n;

	frame_rec_t              rec_q;
	logic [SUM_W-1:0]        mag_q;
	logic signed [MEAN_W-1:0] mean_q;
	logic [SD_W-1:0]         sd_q;
	logic [PROD_W-1:0]       mcand_q;
	logic [SUM_W-1:0]        mplier_q;
	logic [DIFF_W-1:0]       d_q;
	logic [RAD_W-1:0]        v_q;
	logic [DVD_W-1:0]        root_q;
	logic [REM_W-1:0]        rem_q;
	logic [STEP_W-1:0]       step_q;
	logic                    out_valid_q;
	stat_out_t               out_q;

	logic [SUM_W-1:0]        head_mag;
	logic [DIFF_W-1:0]       d_n;
	logic [REM_W+1:0]        rem4;
	logic [REM_W+1:0]        trial;
	logic [REM_W+1:0]        rem_diff;
	logic                    sq_ge;
	logic [DVD_W-1:0]        root_n;
	logic [MEAN_W-1:0]       mean_mag;
	logic                    last_nq;
	logic                    last_ss;
	logic                    last_sqrt;
	logic                    load_out;

	always_comb begin
		head_mag = rec.sum[SUM_W-1] ? (~rec.sum + SUM_W'(1)) : rec.sum;

		// shift-add multiply: N*Q added, then S*S subtracted
		d_n = d_q;
		if (mplier_q[0]) begin
			if (state_q == ST_MUL_SS)
				d_n = d_q - {1'b0, mcand_q};
			else
				d_n = d_q + {1'b0, mcand_q};
		end

		// digit-by-digit square root, two radicand bits per step
		rem4     = {rem_q, v_q[RAD_W-1 -: 2]};
		trial    = {2'b00, root_q, 2'b01};
		sq_ge    = (rem4 >= trial);
		rem_diff = rem4 - trial;
		root_n   = {root_q[DVD_W-2:0], sq_ge};

		mean_mag = div_rsp.quotient[MEAN_W-1:0]
			+ MEAN_W'(div_rsp.remainder != '0);

		last_nq   = (step_q == STEP_W'(CNT_W-1));
		last_ss   = (step_q == STEP_W'(SUM_W-1));
		last_sqrt = (step_q == STEP_W'(DVD_W-1));
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE:   if (rec_valid) state_n = ST_MEAN;
			ST_MEAN:   if (div_rsp.done) state_n = ST_MUL_NQ;
			ST_MUL_NQ: if (last_nq) state_n = ST_MUL_SS;
			ST_MUL_SS: if (last_ss) state_n = ST_SQRT;
			ST_SQRT:   if (last_sqrt) state_n = ST_SD;
			ST_SD:     if (div_rsp.done) state_n = ST_OUT;
			ST_OUT:    if (!out_valid_q || pop) state_n = ST_IDLE;
			default:   state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		rec_pop          = (state_q == ST_IDLE) && rec_valid;
		load_out         = (state_q == ST_OUT) && (!out_valid_q || pop);
		div_req.start    = rec_pop || ((state_q == ST_SQRT) && last_sqrt);
		div_req.dividend = rec_pop ? {head_mag, 8'b0} : root_n;
		div_req.divisor  = rec_pop ? rec.count : rec_q.count;
	end

	always_ff @(posedge clk) begin
		if (rec_pop) begin
			rec_q <= rec;
			mag_q <= head_mag;
		end
		case (state_q)
			ST_MEAN: begin
				if (div_rsp.done) begin
					// floor for negative sums: -(q + (r != 0)); plain quotient otherwise
					mean_q   <= rec_q.sum[SUM_W-1] ? -signed'(mean_mag)
					            : signed'(div_rsp.quotient[MEAN_W-1:0]);
					mcand_q  <= PROD_W'(rec_q.sumsq);
					mplier_q <= SUM_W'(rec_q.count);
					d_q      <= '0;
					step_q   <= '0;
				end
			end
			ST_MUL_NQ: begin
				d_q    <= d_n;
				step_q <= step_q + STEP_W'(1);
				if (last_nq) begin
					mcand_q  <= PROD_W'(mag_q);
					mplier_q <= mag_q;
					step_q   <= '0;
				end else begin
					mcand_q  <= {mcand_q[PROD_W-2:0], 1'b0};
					mplier_q <= {1'b0, mplier_q[SUM_W-1:1]};
				end
			end
			ST_MUL_SS: begin
				d_q    <= d_n;
				step_q <= step_q + STEP_W'(1);
				mcand_q  <= {mcand_q[PROD_W-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[SUM_W-1:1]};
				if (last_ss) begin
					v_q    <= d_n[DIFF_W-1] ? '0 : {d_n[PROD_W-1:0], 16'b0};
					root_q <= '0;
					rem_q  <= '0;
					step_q <= '0;
				end
			end
			ST_SQRT: begin
				v_q    <= {v_q[RAD_W-3:0], 2'b00};
				root_q <= root_n;
				rem_q  <= sq_ge ? rem_diff[REM_W-1:0] : rem4[REM_W-1:0];
				step_q <= step_q + STEP_W'(1);
			end
			ST_SD: begin
				if (div_rsp.done)
					sd_q <= div_rsp.quotient[SD_W-1:0];
			end
			default: ;
		endcase
		if (load_out) begin
			out_q.total       <= rec_q.sum;
			out_q.mean_q8     <= mean_q;
			out_q.std_dev_q8  <= sd_q;
			out_q.valid_count <= rec_q.count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	import psms_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;
	localparam int TAIL_CYCLES = 250;     // idle tail after the last result is checked

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      push = 1'b0;
	logic      pop = 1'b0;
	pix_in_t   item = '0;
	logic      full;
	logic      empty;
	stat_out_t result;

	// frame accumulators of the predictor
	longint run_sum = 0;
	longint run_sumsq = 0;
	int     run_count = 0;

	stat_out_t stats_due[$];
	int        error_count = 0;
	int        cycle_count = 0;
	int        send_idle_pct = 0;
	int        recv_idle_pct = 0;
	int        pop_hold_req = 0;
	int        pop_hold_left = 0;

	pixel_sum_mean_stddev dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout at cycle %0d, %0d results outstanding",
				cycle_count, stats_due.size());
			$display("pixel_sum_mean_stddev verification failed");
			$finish;
		end
	end

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		if (error_count < 50)
			$display("MISMATCH cycle %0d %s: got %0d expected %0d", cycle_count, what, got, want);
		error_count++;
	endtask

	function automatic void predict_pixel(input pix_in_t px);
		stat_out_t    r;
		longint       sample, scaled, mean_v, mag;
		logic [127:0] prod_nq, prod_ss, radicand, root, trial;
		int           k;
		sample = {{48{px.pixel[PIX_W-1]}}, px.pixel};
		if (px.pixel_valid && run_count < int'(MAX_PIXELS)) begin
			run_count++;
			run_sum += sample;
			run_sumsq += sample * sample;
		end
		if (px.frame_last) begin
			if (run_count != 0) begin
				scaled = run_sum * 256;
				mean_v = scaled / longint'(run_count);
				// division truncates toward zero; want floor
				if (scaled % longint'(run_count) != 0 && scaled < 0)
					mean_v--;
				mag = (run_sum < 0) ? -run_sum : run_sum;
				prod_nq = 128'(run_count) * 128'(run_sumsq);
				prod_ss = 128'(mag) * 128'(mag);
				radicand = (prod_ss <= prod_nq) ? (prod_nq - prod_ss) << 16 : '0;
				root = '0;
				for (k = 63; k >= 0; k--) begin
					trial = root | (128'(1) << k);
					if (trial * trial <= radicand)
						root = trial;
				end
				r.total = run_sum[SUM_W-1:0];
				r.mean_q8 = mean_v[MEAN_W-1:0];
				r.std_dev_q8 = SD_W'(root / 128'(run_count));
				r.valid_count = run_count[CNT_W-1:0];
				stats_due.push_back(r);
			end
			run_sum = 0;
			run_sumsq = 0;
			run_count = 0;
		end
	endfunction

	// pop side: random idling, or a long hold-off counted here
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (pop_hold_left > 0) begin
			pop <= 1'b0;
			pop_hold_left--;
		end else if (pop_hold_req > 0) begin
			pop <= 1'b0;
			pop_hold_left = pop_hold_req - 1;
			pop_hold_req = 0;
		end else begin
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin : check_results
		stat_out_t want;
		if (arst_n && pop && !empty) begin
			if (stats_due.size() == 0) begin
				flag_mismatch("unexpected result, total", result.total, 0);
			end else begin
				want = stats_due.pop_front();
				if (result.total !== want.total)
					flag_mismatch("total", result.total, want.total);
				if (result.mean_q8 !== want.mean_q8)
					flag_mismatch("mean_q8", result.mean_q8, want.mean_q8);
				if (result.std_dev_q8 !== want.std_dev_q8)
					flag_mismatch("std_dev_q8", result.std_dev_q8, want.std_dev_q8);
				if (result.valid_count !== want.valid_count)
					flag_mismatch("valid_count", result.valid_count, want.valid_count);
			end
		end
	end

	// push stays high on return so back-to-back requests need no gap
	task automatic send_pixel(input logic signed [PIX_W-1:0] px, input logic v,
			input logic last);
		pix_in_t req;
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		req.pixel = px;
		req.pixel_valid = v;
		req.frame_last = last;
		item <= req;
		push <= 1'b1;
		@(posedge clk);
		while (full)
			@(posedge clk);
		predict_pixel(req);
	endtask

	task automatic wait_all_results();
		push <= 1'b0;
		@(posedge clk);
		while (stats_due.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [PIX_W-1:0] rand_pixel();
		logic signed [PIX_W-1:0] v;
		case ($urandom_range(7))
			0: v = 16'sh8000;
			1: v = 16'sh7FFF;
			2, 3: v = 16'($urandom_range(32)) - 16'sd16;
			default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	task automatic send_random_frame(inout int sent);
		int                      len, mode, k;
		logic signed [PIX_W-1:0] level, px;
		logic                    v;
		case ($urandom_range(99)) inside
			[0:69]: len = $urandom_range(8, 1);
			[70:94]: len = $urandom_range(40, 9);
			default: len = $urandom_range(120, 41);
		endcase
		mode = $urandom_range(9);
		level = rand_pixel();
		for (k = 0; k < len; k++) begin
			case (mode)
				0: begin            // every pixel skipped, no result
					px = 16'($urandom);
					v = 1'b0;
				end
				1: begin            // flat frame, zero deviation
					px = level;
					v = 1'b1;
				end
				default: begin
					px = rand_pixel();
					v = ($urandom_range(99) < 85);
				end
			endcase
			send_pixel(px, v, k == len - 1);
			sent++;
		end
	endtask

	task automatic test_directed();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_pixel(16'sh7FFF, 1'b1, 1'b1);
		send_pixel(16'sh8000, 1'b1, 1'b1);
		send_pixel(16'sd0, 1'b1, 1'b1);
		// empty frames: nothing comes out
		send_pixel(16'sh7FFF, 1'b0, 1'b1);
		send_pixel(16'sh8000, 1'b0, 1'b0);
		send_pixel(16'sh5A5A, 1'b0, 1'b1);
		// widest spread
		send_pixel(16'sh7FFF, 1'b1, 1'b0);
		send_pixel(16'sh8000, 1'b1, 1'b1);
		// negative mean that does not divide evenly
		send_pixel(-16'sd1, 1'b1, 1'b0);
		send_pixel(16'sd0, 1'b1, 1'b0);
		send_pixel(16'sd0, 1'b1, 1'b1);
		// skipped last pixel still closes the frame
		send_pixel(16'sd5, 1'b1, 1'b0);
		send_pixel(16'sh7FFF, 1'b0, 1'b0);
		send_pixel(16'sd7, 1'b1, 1'b0);
		send_pixel(16'sh8000, 1'b0, 1'b1);
		send_pixel(16'sd3, 1'b1, 1'b0);
		send_pixel(-16'sd4, 1'b1, 1'b0);
		send_pixel(16'sd2, 1'b1, 1'b1);
		wait_all_results();
	endtask

	task automatic test_random(input int count, input int send_pct, input int recv_pct);
		int sent;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		sent = 0;
		while (sent < count)
			send_random_frame(sent);
	endtask

	// result side stalls for a long time while short frames keep coming
	task automatic test_input_backpressure();
		int k;
		send_idle_pct = 0;
		pop_hold_req = 2000;
		for (k = 0; k < 40; k++)
			send_pixel(rand_pixel(), 1'b1, ($urandom_range(2) == 0) || k == 39);
	endtask

	task automatic test_drain_pause();
		int sent;
		sent = 0;
		send_random_frame(sent);
		wait_all_results();
		send_random_frame(sent);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(500, 10, 80);
		test_input_backpressure();
		test_random(500, 80, 10);
		test_drain_pause();
		test_random(500, 0, 0);
		wait_all_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("pixel_sum_mean_stddev verification clean");
		end else begin
			$display("pixel_sum_mean_stddev verification failed");
		end
		$finish;
	end

endmodule

// ===== pixel_sum_mean_stddev.f =====
sv/psms_pkg.sv
sv/psms_front.sv
sv/psms_fifo.sv
sv/psms_div.sv
sv/psms_back.sv
sv/pixel_sum_mean_stddev.sv
test/testbench.sv
